// ===== rtl/core/rsi_pkg.sv =====
// Shared constants for the relative strength index block.
package rsi_pkg;

  localparam int PRICE_BITS_DEF  = 32;
  localparam int PERIOD_BITS_DEF = 8;
  localparam int RET_BITS        = 32;
  localparam int RSI_BITS        = 23;
  localparam int CFG_BITS        = 8;
  localparam logic [CFG_BITS-1:0] PERIOD_RESET = 8'd14;
  localparam logic [RSI_BITS-1:0] RSI_NO_LOSS  = 23'd6488712;
  localparam logic [RSI_BITS-1:0] RSI_FULL     = 23'd6553600;
  localparam logic [RET_BITS-1:0] RET_MAX      = 32'h7FFF_FFFF;

endpackage

// ===== rtl/core/rsi_div.sv =====
// Restoring bit-serial divider: one quotient bit per cycle.
module rsi_div #(
  parameter int NUM_BITS = 48,
  parameter int DEN_BITS = 48
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic [NUM_BITS-1:0] numer,
  input  logic [DEN_BITS-1:0] denom,
  output logic                busy,
  output logic                done,
  output logic [NUM_BITS-1:0] quot
);

  localparam int CNT_BITS = $clog2(NUM_BITS + 1);

  logic [DEN_BITS:0]     rem;
  logic [DEN_BITS:0]     trial;
  logic [DEN_BITS:0]     diff;
  logic [CNT_BITS-1:0]   count;

  assign trial = {rem[DEN_BITS-1:0], quot[NUM_BITS-1]};
  assign diff  = trial - {1'b0, denom};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        count <= CNT_BITS'(NUM_BITS);
        rem   <= '0;
        quot  <= numer;
      end else if (busy) begin
        if (!diff[DEN_BITS]) begin
          rem  <= diff;
          quot <= {quot[NUM_BITS-2:0], 1'b1};
        end else begin
          rem  <= trial;
          quot <= {quot[NUM_BITS-2:0], 1'b0};
        end
        count <= count - 1'b1;
        if (count == CNT_BITS'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("divider done while busy");
  assert property (@(posedge clk) disable iff (rst) start |=> busy)
    else $error("divider did not start");
  assert property (@(posedge clk) disable iff (rst) $fell(busy) |-> done)
    else $error("divider stopped without done");

endmodule

// ===== rtl/core/relative_strength_index.sv =====
// Top level: Wilder relative strength index over a stream of Q16.16 prices.
// A smoothed item runs up to four serial DW-bit divisions (DW = PRICE_BITS + 32, at least 56)
// and a shift-add multiply over the PERIOD_BITS bits of the period. An item that ends in
// seeding runs the return division unless clipped, then the two seeding divisions. A first
// price is kept. One item at a time; a waiting result stalls the core only at its next result.
// Reset: synchronous; clears the series state and sets the period to 14.
module relative_strength_index #(
  parameter int PRICE_BITS  = rsi_pkg::PRICE_BITS_DEF,
  parameter int PERIOD_BITS = rsi_pkg::PERIOD_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic [PRICE_BITS-1:0]           price,
  input  logic                            series_start,
  input  logic                            in_valid,
  output logic                            in_ready,
  output logic [rsi_pkg::RSI_BITS-1:0]    rsi_value,
  output logic                            return_clipped,
  output logic                            out_valid,
  input  logic                            out_ready,
  input  logic [rsi_pkg::CFG_BITS-1:0]    cfg_data,
  input  logic                            cfg_valid,
  output logic                            cfg_ready
);

  localparam int RET_BITS_L = rsi_pkg::RET_BITS;
  localparam int AVG_BITS = 32 + PERIOD_BITS;
  localparam int DW       = (PRICE_BITS + 32 > 56) ? PRICE_BITS + 32 : 56;
  localparam int MUL_BITS = AVG_BITS + PERIOD_BITS;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_RET   = 4'd1;
  localparam logic [3:0] S_ACC   = 4'd2;
  localparam logic [3:0] S_SDG   = 4'd3;
  localparam logic [3:0] S_SDL   = 4'd4;
  localparam logic [3:0] S_MUL   = 4'd5;
  localparam logic [3:0] S_SMG   = 4'd6;
  localparam logic [3:0] S_SML   = 4'd7;
  localparam logic [3:0] S_RSI   = 4'd8;
  localparam logic [3:0] S_OUT   = 4'd9;

  logic [3:0]              state;
  logic [PERIOD_BITS-1:0]  period;
  logic [PRICE_BITS-1:0]   prev, cur;
  logic                    have_prev, seeded, clip, neg;
  logic [AVG_BITS-1:0]     avg_gain, avg_loss;
  logic [PERIOD_BITS-1:0]  seed_count;
  logic [RET_BITS_L-1:0]   mag;
  logic [MUL_BITS-1:0]     prod_g, prod_l;
  logic [PERIOD_BITS-1:0]  mul_cnt;
  logic [PERIOD_BITS-1:0]  mul_sh;

  logic                    div_start, div_busy, div_done;
  logic [DW-1:0]           div_num, div_quot;
  logic [DW-1:0]           div_den;

  logic [PERIOD_BITS-1:0]  per_eff;
  logic [PRICE_BITS-1:0]   diff;
  logic [PRICE_BITS+7:0]   lim;
  logic                    cur_neg_w;

  assign per_eff   = (period == '0) ? PERIOD_BITS'(1) : period;
  assign cur_neg_w = cur < prev;
  assign diff = cur_neg_w ? (prev - cur) : (cur - prev);
  assign lim  = {1'b0, prev, 7'd0};

  assign in_ready  = (state == S_IDLE);
  assign cfg_ready = (state == S_IDLE);

  rsi_div #(.NUM_BITS(DW), .DEN_BITS(DW)) u_div (
    .clk, .rst, .start(div_start), .numer(div_num), .denom(div_den),
    .busy(div_busy), .done(div_done), .quot(div_quot)
  );

  logic [AVG_BITS-1:0] gain_x, loss_x;
  assign gain_x = neg ? '0 : AVG_BITS'(mag);
  assign loss_x = neg ? AVG_BITS'(mag) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      period     <= PERIOD_BITS'(rsi_pkg::PERIOD_RESET);
      prev       <= '0;
      have_prev  <= 1'b0;
      seeded     <= 1'b0;
      avg_gain   <= '0;
      avg_loss   <= '0;
      seed_count <= '0;
      out_valid  <= 1'b0;
      div_start  <= 1'b0;
    end else begin
      div_start <= 1'b0;
      if (cfg_valid && cfg_ready) period <= PERIOD_BITS'(cfg_data);
      if (out_valid && out_ready) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (in_valid && in_ready) begin
            cur <= price;
            if (series_start || !have_prev) begin
              prev      <= price;
              have_prev <= 1'b1;
              if (series_start) begin
                seeded <= 1'b0; avg_gain <= '0; avg_loss <= '0; seed_count <= '0;
              end
            end else if (prev != '0) begin
              state <= S_RET;
            end else begin
              prev <= price;
            end
          end
        end
        S_RET: begin
          neg  <= cur_neg_w;
          prev <= cur;
          if (!cur_neg_w && {8'd0, diff} >= lim) begin
            clip  <= 1'b1;
            mag   <= rsi_pkg::RET_MAX;
            state <= S_ACC;
          end else begin
            clip      <= 1'b0;
            div_num   <= DW'({diff, 24'd0});
            div_den   <= DW'(prev);
            div_start <= 1'b1;
            state     <= S_ACC;
          end
        end
        S_ACC: begin
          if (clip || div_done) begin
            if (!clip) mag <= RET_BITS_L'(div_quot);
            if (!seeded) begin
              if (!clip) begin
                avg_gain <= avg_gain + (neg ? '0 : AVG_BITS'(div_quot));
                avg_loss <= avg_loss + (neg ? AVG_BITS'(div_quot) : '0);
              end else avg_gain <= avg_gain + AVG_BITS'(rsi_pkg::RET_MAX);
              if (seed_count != '1) seed_count <= seed_count + 1'b1;
              if (((seed_count != '1) ? seed_count + 1'b1 : seed_count) >= per_eff)
                state <= S_SDG;
              else
                state <= S_IDLE;
            end else begin
              prod_g  <= '0;
              prod_l  <= '0;
              mul_sh  <= per_eff - 1'b1;
              mul_cnt <= PERIOD_BITS'(PERIOD_BITS);
              state   <= S_MUL;
            end
          end
        end
        S_SDG: begin
          div_num   <= DW'(avg_gain);
          div_den   <= DW'(per_eff);
          div_start <= 1'b1;
          state     <= S_SDL;
        end
        S_SDL: begin
          if (div_done) begin
            if (div_den == DW'(per_eff) && !seeded) begin
              avg_gain  <= AVG_BITS'(div_quot);
              div_num   <= DW'(avg_loss);
              div_start <= 1'b1;
              seeded    <= 1'b1;
            end else begin
              avg_loss <= AVG_BITS'(div_quot);
              state    <= S_IDLE;
            end
          end
        end
        S_MUL: begin
          // Shift-add multiply by (per_eff - 1), most significant bit first.
          prod_g  <= (prod_g << 1) + (mul_sh[PERIOD_BITS-1] ? MUL_BITS'(avg_gain) : '0);
          prod_l  <= (prod_l << 1) + (mul_sh[PERIOD_BITS-1] ? MUL_BITS'(avg_loss) : '0);
          mul_sh  <= mul_sh << 1;
          mul_cnt <= mul_cnt - 1'b1;
          if (mul_cnt == PERIOD_BITS'(1)) begin
            state <= S_SMG;
          end
        end
        S_SMG: begin
          div_num   <= DW'(prod_g + MUL_BITS'(gain_x));
          div_den   <= DW'(per_eff);
          div_start <= 1'b1;
          state     <= S_SML;
          mul_cnt   <= '0;
        end
        S_SML: begin
          if (div_done) begin
            if (mul_cnt == '0) begin
              avg_gain  <= AVG_BITS'(div_quot);
              div_num   <= DW'(prod_l + MUL_BITS'(loss_x));
              div_start <= 1'b1;
              mul_cnt   <= PERIOD_BITS'(1);
            end else begin
              avg_loss <= AVG_BITS'(div_quot);
              state    <= S_RSI;
              mul_cnt  <= '0;
            end
          end
        end
        S_RSI: begin
          if (avg_loss != '0) begin
            // The full scale 6553600 is 100 * 2^16, so it is three shifted copies of the gain.
            div_num   <= (DW'(avg_gain) << 22) + (DW'(avg_gain) << 21)
                         + (DW'(avg_gain) << 18);
            div_den   <= DW'(avg_gain) + DW'(avg_loss);
            div_start <= 1'b1;
            state     <= S_OUT;
          end else if (!out_valid) begin
            rsi_value      <= rsi_pkg::RSI_NO_LOSS;
            return_clipped <= clip;
            out_valid      <= 1'b1;
            state          <= S_IDLE;
          end
        end
        S_OUT: begin
          // The quotient holds until the next start, so a busy output can be waited out.
          if (!div_start && !div_busy && !out_valid) begin
            rsi_value      <= rsi_pkg::RSI_BITS'(div_quot);
            return_clipped <= clip;
            out_valid      <= 1'b1;
            state          <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> ($stable(rsi_value) && $stable(return_clipped)))
    else $error("result changed while waiting");
  assert property (@(posedge clk) disable iff (rst) in_ready |-> !div_busy)
    else $error("input taken while divider busy");
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> out_valid)
    else $error("result dropped");

endmodule

// ===== bench/testbench.sv =====
// Self-checking testbench for the relative strength index block.
module testbench;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DRAIN_CYCLES   = 400;

  typedef struct packed {
    logic [rsi_pkg::RSI_BITS-1:0] rsi;
    logic                         clipped;
  } rsi_result_t;

  // Predicts RSI results from accepted prices and checks the block's outputs.
  class rsi_scoreboard;
    logic [7:0]   period;
    logic [31:0]  last_price;
    bit           have_last;
    logic [63:0]  gain_avg;
    logic [63:0]  loss_avg;
    int unsigned  seeds_taken;
    bit           seed_done;
    rsi_result_t  pending[$];
    int unsigned  errors;

    function new();
      period = rsi_pkg::PERIOD_RESET;
      errors = 0;
      restart();
    endfunction

    function void restart();
      last_price = 0;
      have_last = 0;
      gain_avg = 0;
      loss_avg = 0;
      seeds_taken = 0;
      seed_done = 0;
    endfunction

    function void note_price(logic [31:0] cur, logic start);
      logic [63:0] prv, diff, quot, gain, loss, div, total;
      bit neg, clip;
      rsi_result_t res;
      if (start) restart();
      if (!have_last) begin
        last_price = cur;
        have_last = 1;
        return;
      end
      prv = last_price;
      last_price = cur;
      if (prv == 0) return;
      neg = cur < prv;
      clip = 0;
      diff = neg ? prv - cur : cur - prv;
      if (!neg && diff >= (prv << 7)) begin
        clip = 1;
        quot = 64'(rsi_pkg::RET_MAX);
      end else begin
        quot = (diff << 24) / prv;
      end
      gain = neg ? 64'd0 : quot;
      loss = neg ? quot : 64'd0;
      div = (period == 0) ? 64'd1 : 64'(period);
      if (!seed_done) begin
        gain_avg += gain;
        loss_avg += loss;
        if (seeds_taken < 255) seeds_taken++;
        if (seeds_taken >= div) begin
          gain_avg /= div;
          loss_avg /= div;
          seed_done = 1;
        end
        return;
      end
      gain_avg = (gain_avg * (div - 1) + gain) / div;
      loss_avg = (loss_avg * (div - 1) + loss) / div;
      if (loss_avg == 0) begin
        res.rsi = rsi_pkg::RSI_NO_LOSS;
      end else begin
        total = gain_avg + loss_avg;
        res.rsi = rsi_pkg::RSI_BITS'((64'(rsi_pkg::RSI_FULL) * gain_avg) / total);
      end
      res.clipped = clip;
      pending = {pending, res};
    endfunction

    function void check_result(logic [rsi_pkg::RSI_BITS-1:0] rsi, logic clipped);
      rsi_result_t exp_res;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result rsi=%0d clipped=%0b", $realtime, rsi, clipped);
        errors++;
        return;
      end
      exp_res = pending.pop_front();
      if (rsi !== exp_res.rsi) begin
        $display("%0t: rsi_value expected %0d actual %0d", $realtime, exp_res.rsi, rsi);
        errors++;
      end
      if (clipped !== exp_res.clipped) begin
        $display("%0t: return_clipped expected %0b actual %0b",
                 $realtime, exp_res.clipped, clipped);
        errors++;
      end
    endfunction
  endclass

  logic                         clk = 0;
  logic                         rst = 1;
  logic [31:0]                  price = 0;
  logic                         series_start = 0;
  logic                         in_valid = 0;
  logic                         in_ready;
  logic [rsi_pkg::RSI_BITS-1:0] rsi_value;
  logic                         return_clipped;
  logic                         out_valid;
  logic                         out_ready = 0;
  logic [rsi_pkg::CFG_BITS-1:0] cfg_data = 0;
  logic                         cfg_valid = 0;
  logic                         cfg_ready;

  rsi_scoreboard board = new();
  int unsigned   send_idle_pct = 36;
  int unsigned   recv_idle_pct = 68;
  bit            hold_off = 0;
  int unsigned   quiet_cycles = 0;

  relative_strength_index dut (
    .clk(clk), .rst(rst),
    .price(price), .series_start(series_start), .in_valid(in_valid), .in_ready(in_ready),
    .rsi_value(rsi_value), .return_clipped(return_clipped),
    .out_valid(out_valid), .out_ready(out_ready),
    .cfg_data(cfg_data), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready)
  );

  always begin
    #6 clk = 1;
    #6 clk = 0;
  end

  // Receiver: check on the rising edge, choose ready on the falling edge.
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) board.check_result(rsi_value, return_clipped);
  end

  always @(negedge clk) begin
    out_ready <= !rst && !hold_off && ($urandom_range(99) >= recv_idle_pct);
  end

  // Watchdog on cycles without any transaction.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Valid stays high after a transaction until the sender idles or the phase ends.
  task automatic send_price(logic [31:0] p, logic start);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 0;
      @(negedge clk);
    end
    price <= p;
    series_start <= start;
    in_valid <= 1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    board.note_price(p, start);
    @(negedge clk);
  endtask

  task automatic wait_idle();
    in_valid <= 0;
    while (board.pending.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_period(logic [7:0] value);
    cfg_data <= value;
    cfg_valid <= 1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    board.period = value;
    @(negedge clk);
    cfg_valid <= 0;
  endtask

  function automatic logic [31:0] random_price();
    case ($urandom_range(9))
      0: return $urandom;
      1: return $urandom_range(3);
      2: return 32'hFFFF_FFFF - $urandom_range(3);
      default: return 32'h0001_0000 + $urandom_range(32'h0008_0000);
    endcase
  endfunction

  // Series: a start, then prices that mostly drift by small steps, with rare jumps and restarts.
  task automatic random_series(int count);
    logic [31:0] p;
    logic [31:0] step;
    p = 32'h0010_0000 + $urandom_range(32'h0100_0000);
    send_price(p, 1);
    for (int i = 1; i < count; i++) begin
      if ($urandom_range(19) == 0) begin
        p = random_price();
      end else begin
        step = $urandom_range(p >> 4);
        p = $urandom_range(1) ? p + step : p - step;
      end
      send_price(p, $urandom_range(49) == 0);
    end
  endtask

  initial begin
    repeat (3) @(negedge clk);
    rst <= 0;

    // Directed: short period, extremes, zero prices, clipping, flat series.
    write_period(8'd2);
    send_price(32'h0001_0000, 1);
    send_price(32'h0002_0000, 0);
    send_price(32'h0001_0000, 0);
    send_price(32'hFFFF_FFFF, 0);
    send_price(32'h0000_0000, 0);
    send_price(32'h0000_0005, 0);
    send_price(32'h0000_0001, 0);
    send_price(32'hFFFF_FFFF, 0);
    send_price(32'h0000_0000, 0);
    send_price(32'h0001_0000, 1);
    send_price(32'h0001_0000, 0);
    send_price(32'h0001_0000, 0);
    send_price(32'h0001_0000, 0);
    send_price(32'h0002_0000, 0);
    send_price(32'h0001_0000, 0);
    wait_idle();
    write_period(8'd0);
    send_price(32'h0100_0000, 1);
    send_price(32'h0080_0000, 0);
    send_price(32'h0090_0000, 0);
    send_price(32'h0000_0000, 0);
    send_price(32'h0010_0000, 0);
    send_price(32'h0011_0000, 0);
    wait_idle();

    // Random phases with varied idling and periods.
    write_period(8'd1);
    for (int s = 0; s < 8; s++) random_series(30);
    wait_idle();
    write_period(8'd255);
    random_series(270);
    wait_idle();

    send_idle_pct = 68;
    recv_idle_pct = 36;
    write_period(8'd14);
    for (int s = 0; s < 4; s++) random_series(25);
    wait_idle();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_period(8'd3);
    fork
      random_series(60);
      begin
        hold_off = 1;
        repeat (2000) @(negedge clk);
        hold_off = 0;
      end
    join
    wait_idle();

    while (board.pending.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (board.errors == 0 && board.pending.size() == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end
endmodule
